FILE: design/byte_ring_buffer_with_overflow_flags_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the byte ring buffer
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_BUFFER_WITH_OVERFLOW_FLAGS_ASSERT_SVH
`define BYTE_RING_BUFFER_WITH_OVERFLOW_FLAGS_ASSERT_SVH

// Same-cycle implication.
`define BRB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/brb_pkg.sv
// ----------------------------------------------------------------------------
// brb_pkg
// Shared codes, field widths and control types of the byte ring buffer.
// ----------------------------------------------------------------------------
package brb_pkg;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned CFG_W    = 9;
  localparam int unsigned RES_W    = 30;
  localparam int unsigned OUT_W    = 32;

  localparam logic [FUNC_W-1:0] FN_PUSH  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_POP   = 2'd1;
  localparam logic [FUNC_W-1:0] FN_RESET = 2'd2;
  localparam logic [FUNC_W-1:0] FN_CLROV = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_WRAP  = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVF   = 2'd2;

  typedef struct packed {
    logic clear;     // zero one store entry
    logic accept;    // take the input word
    logic load_out;  // build the result word
  } brb_cmd_t;

  typedef struct packed {
    logic clr_last;  // clearing pass is at its last entry
  } brb_sts_t;

endpackage

FILE: design/brb_ctrl.sv
// ----------------------------------------------------------------------------
// brb_ctrl
// Sequencer: clearing pass after reset, then accept, load and hold per word.
// ----------------------------------------------------------------------------
module brb_ctrl
  import brb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  brb_sts_t sts,
  output brb_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_LOAD  = 4'b0100,
    S_HOLD  = 4'b1000
  } brb_state_t;

  brb_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready    = (state_r == S_IDLE);
  assign out_tvalid   = (state_r == S_HOLD);
  assign cmd.clear    = (state_r == S_CLEAR);
  assign cmd.accept   = (state_r == S_IDLE) && in_tvalid;
  assign cmd.load_out = (state_r == S_LOAD);

endmodule

FILE: design/brb_dpath.sv
// ----------------------------------------------------------------------------
// brb_dpath
// Byte store, pointers, sticky flags, size register and result register.
// ----------------------------------------------------------------------------
module brb_dpath
  import brb_pkg::*;
#(
  parameter int unsigned DEPTH = 256
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  brb_cmd_t          cmd,
  output brb_sts_t          sts,
  input  logic [FUNC_W-1:0] func,
  input  logic [BYTE_W-1:0] push_byte,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_data,
  output logic [RES_W-1:0]  result
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [16:0] DEPTH17 = 17'(DEPTH);
  localparam logic [16:0] RST17   = (DEPTH < 256) ? 17'(DEPTH) : 17'd256;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_r;

  logic [CW-1:0]     size_r, size_nxt;
  logic [IW-1:0]     wr_idx_r, wr_idx_nxt;
  logic [IW-1:0]     rd_idx_r, rd_idx_nxt;
  logic              ovf_r, ovf_nxt;
  logic              wrap_r, wrap_nxt;
  logic [IW-1:0]     clr_idx_r;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic              pop_en_r;
  logic [RES_W-1:0]  out_r;

  logic [16:0]       cfg17, clamp17;
  logic [CW-1:0]     wadv, radv;
  logic              wwrap, rwrap;
  logic [IW-1:0]     wnew, rnew;

  logic [CW-1:0]     count, free_b, cap;
  logic [CW+7:0]     count_ext, free_ext;

  // Clamp the size write into 2..DEPTH.
  always_comb begin
    cfg17 = {8'h00, cfg_data};
    if (cfg17 < 17'd2) begin
      clamp17 = 17'd2;
    end else if (cfg17 > DEPTH17) begin
      clamp17 = DEPTH17;
    end else begin
      clamp17 = cfg17;
    end
  end

  assign wadv  = CW'(wr_idx_r) + CW'(1);
  assign wwrap = (wadv >= size_r);
  assign wnew  = wwrap ? '0 : wadv[IW-1:0];
  assign radv  = CW'(rd_idx_r) + CW'(1);
  assign rwrap = (radv >= size_r);
  assign rnew  = rwrap ? '0 : radv[IW-1:0];

  always_comb begin
    size_nxt   = size_r;
    wr_idx_nxt = wr_idx_r;
    rd_idx_nxt = rd_idx_r;
    ovf_nxt    = ovf_r;
    wrap_nxt   = wrap_r;
    status_nxt = ST_OK;
    if (cfg_we) begin
      size_nxt   = clamp17[CW-1:0];
      wr_idx_nxt = '0;
      rd_idx_nxt = '0;
      ovf_nxt    = 1'b0;
      wrap_nxt   = 1'b0;
    end else if (cmd.accept) begin
      case (func)
        FN_PUSH: begin
          wr_idx_nxt = wnew;
          if (wwrap) begin
            wrap_nxt   = 1'b1;
            status_nxt = ST_WRAP;
          end
          // overflow wins over wrap
          if (wnew == rd_idx_r) begin
            ovf_nxt    = 1'b1;
            status_nxt = ST_OVF;
          end
        end
        FN_POP: begin
          rd_idx_nxt = rnew;
        end
        FN_RESET: begin
          wr_idx_nxt = '0;
          rd_idx_nxt = '0;
          ovf_nxt    = 1'b0;
          wrap_nxt   = 1'b0;
        end
        default: begin
          ovf_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r    <= RST17[CW-1:0];
      wr_idx_r  <= '0;
      rd_idx_r  <= '0;
      ovf_r     <= 1'b0;
      wrap_r    <= 1'b0;
      clr_idx_r <= '0;
    end else begin
      size_r   <= size_nxt;
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      ovf_r    <= ovf_nxt;
      wrap_r   <= wrap_nxt;
      if (cmd.clear) clr_idx_r <= clr_idx_r + IW'(1);
    end
  end

  assign sts.clr_last = (clr_idx_r == IW'(DEPTH - 1));

  // Store: one write port shared by the clearing pass and pushes.
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[clr_idx_r] <= '0;
    end else if (cmd.accept && (func == FN_PUSH)) begin
      mem[wr_idx_r] <= push_byte;
    end
  end

  // Read at the old read pointer as the word is taken.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rdata_r  <= mem[rd_idx_r];
      pop_en_r <= (func == FN_POP);
      status_r <= status_nxt;
    end
  end

  always_comb begin
    if (wr_idx_r >= rd_idx_r) begin
      count = CW'(wr_idx_r) - CW'(rd_idx_r);
    end else begin
      count = size_r - CW'(rd_idx_r) + CW'(wr_idx_r);
    end
    cap       = size_r - CW'(1);
    free_b    = cap - count;
    count_ext = {8'h00, count};
    free_ext  = {8'h00, free_b};
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r <= {wrap_r, ovf_r, (count == '0), (free_b == '0),
                free_ext[7:0], count_ext[7:0], status_r,
                pop_en_r ? rdata_r : 8'h00};
    end
  end

  assign result = out_r;

endmodule

FILE: design/byte_ring_buffer_with_overflow_flags.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer_with_overflow_flags
// Byte ring buffer with push, pop, pointer reset and sticky overflow/wrap flags.
// ----------------------------------------------------------------------------
// After reset the block zeroes its DEPTH-entry byte store, one entry a cycle,
// and takes no word until that pass ends; size writes on the cfg channel
// are taken throughout. One word is handled at a time: it is taken while
// the block is idle, the result is built from the registered store read in
// the next cycle, and it is offered in the cycle after that and held until
// out_tready. A size write clamps to 2..DEPTH and clears both pointers and
// both flags; the store keeps its contents.
`include "byte_ring_buffer_with_overflow_flags_assert.svh"

module byte_ring_buffer_with_overflow_flags
  import brb_pkg::*;
#(
  parameter int unsigned DEPTH = 256
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] push_byte
  input  logic [1:0]        in_tuser,   // [1:0] func
  output logic              out_tvalid,
  input  logic              out_tready,
  // [7:0] pop_byte, [9:8] push_status, [17:10] fill_count,
  // [25:18] free_space, [26] is_full, [27] is_empty,
  // [28] overflow_flag, [29] turnaround_flag, [31:30] zero
  output logic [OUT_W-1:0]  out_tdata,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_data
);

  brb_cmd_t         cmd;
  brb_sts_t         sts;
  logic [RES_W-1:0] result;

  assign cfg_ready = 1'b1;

  brb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  brb_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .func      (in_tuser),
    .push_byte (in_tdata),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .result    (result)
  );

  assign out_tdata = {{(OUT_W - RES_W){1'b0}}, result};

  `BRB_ASSERT_NOW(a_one_word, in_tready, !out_tvalid, "input taken while result pending")
  `BRB_ASSERT_NEXT(a_load_after_accept, cmd.accept, cmd.load_out && !in_tready, "no build after accept")
  `BRB_ASSERT_NOW(a_no_accept_in_clear, cmd.clear, !in_tready && !cmd.accept, "word taken during clear")

endmodule

FILE: tb/brb_ring_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_ring_checker
// Watches the word, result and size channels of the byte ring buffer, keeps
// its own copy of the store, pointers and sticky flags, predicts every result
// and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module brb_ring_checker
  import brb_pkg::*;
#(
  parameter int unsigned DEPTH = 256
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] push_byte
  input  logic [1:0]        in_tuser,   // [1:0] func
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [OUT_W-1:0]  out_tdata,  // result fields, see ring_result_t
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_data,
  output int unsigned       fail_count,
  output int unsigned       pending,
  output int unsigned       checked,
  output int unsigned       wrap_count,
  output int unsigned       ovf_count
);

  // Packed from the top field down so that pop_byte lands in bits [7:0].
  typedef struct packed {
    logic              turnaround;
    logic              overflow;
    logic              empty;
    logic              full;
    logic [7:0]        free_space;
    logic [7:0]        fill_count;
    logic [STAT_W-1:0] status;
    logic [7:0]        pop_byte;
  } ring_result_t;

  logic [7:0]    ring_bytes [DEPTH];
  int unsigned   wr_idx;
  int unsigned   rd_idx;
  int unsigned   size_reg;
  logic          ovf_flag;
  logic          wrap_flag;
  ring_result_t  awaited_results [$];
  int unsigned   fails;
  int unsigned   matched;
  int unsigned   wraps;
  int unsigned   ovfs;

  function automatic void reset_pointers();
    wr_idx    = 0;
    rd_idx    = 0;
    ovf_flag  = 1'b0;
    wrap_flag = 1'b0;
  endfunction

  function automatic int unsigned active_slots();
    if (size_reg < 2) return 2;
    if (size_reg > DEPTH) return DEPTH;
    return size_reg;
  endfunction

  // Apply one word to the ring and return the result it should produce.
  function automatic ring_result_t ring_outcome(input logic [FUNC_W-1:0] fn,
                                                input logic [7:0] data);
    ring_result_t r;
    int unsigned  slots;
    int unsigned  cap;
    int unsigned  count;
    int unsigned  room;
    slots = active_slots();
    cap   = slots - 1;
    r     = '0;
    case (fn)
      FN_PUSH: begin
        ring_bytes[wr_idx] = data;
        wr_idx++;
        if (wr_idx >= slots) begin
          wr_idx    = 0;
          wrap_flag = 1'b1;
          r.status  = ST_WRAP;
        end
        // overflow beats wrap in the status
        if (wr_idx == rd_idx) begin
          ovf_flag = 1'b1;
          r.status = ST_OVF;
        end
      end
      FN_POP: begin
        r.pop_byte = ring_bytes[rd_idx];
        rd_idx++;
        if (rd_idx >= slots) rd_idx = 0;
      end
      FN_RESET: reset_pointers();
      default: ovf_flag = 1'b0;
    endcase
    if (wr_idx >= rd_idx) count = wr_idx - rd_idx;
    else count = slots - rd_idx + wr_idx;
    room         = cap - count;
    r.fill_count = count[7:0];
    r.free_space = room[7:0];
    r.full       = (room == 0);
    r.empty      = (room == cap);
    r.overflow   = ovf_flag;
    r.turnaround = wrap_flag;
    return r;
  endfunction

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    ring_result_t got;
    ring_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) ring_bytes[i] = 8'h00;
      reset_pointers();
      size_reg = 256;
      awaited_results.delete();
      fails   = 0;
      matched = 0;
      wraps   = 0;
      ovfs    = 0;
    end else begin
      // check the result first so a word taken at this edge cannot match it
      if (out_tvalid && out_tready) begin
        got = ring_result_t'(out_tdata[RES_W-1:0]);
        if (awaited_results.size() == 0) begin
          $display("%0t: result with nothing awaited, expected none actual %h",
                   $time, out_tdata);
          fails++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("pop_byte", want.pop_byte, got.pop_byte);
          compare_field("push_status", want.status, got.status);
          compare_field("fill_count", want.fill_count, got.fill_count);
          compare_field("free_space", want.free_space, got.free_space);
          compare_field("is_full", want.full, got.full);
          compare_field("is_empty", want.empty, got.empty);
          compare_field("overflow_flag", want.overflow, got.overflow);
          compare_field("turnaround_flag", want.turnaround, got.turnaround);
          matched++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        size_reg = cfg_data;
        reset_pointers();
      end
      if (in_tvalid && in_tready) begin
        want = ring_outcome(in_tuser, in_tdata);
        if (want.status == ST_WRAP) wraps++;
        if (want.status == ST_OVF) ovfs++;
        awaited_results.push_back(want);
      end
    end
    fail_count <= fails;
    pending    <= awaited_results.size();
    checked    <= matched;
    wrap_count <= wraps;
    ovf_count  <= ovfs;
  end

endmodule

FILE: tb/byte_ring_buffer_with_overflow_flags_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_buffer_with_overflow_flags_tb
// Drives pushes, pops, pointer resets and overflow clears into the ring
// buffer under a range of active sizes, with random gaps on both channels
// and one long result stall; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module byte_ring_buffer_with_overflow_flags_tb;
  import brb_pkg::*;

  localparam int unsigned DEPTH          = 256;
  localparam int unsigned LONG_HOLD      = 60;
  localparam int unsigned TIMEOUT_CYCLES = 200_000;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata   = '0;
  logic [1:0]        in_tuser   = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_data   = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned wrap_count;
  int unsigned ovf_count;

  int unsigned op_count [4];
  int unsigned size_writes = 0;
  int unsigned long_holds  = 0;
  logic        quiet       = 1'b0;
  logic        long_hold_req = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  byte_ring_buffer_with_overflow_flags #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  brb_ring_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending),
    .checked   (checked),
    .wrap_count(wrap_count),
    .ovf_count (ovf_count)
  );

  // Result side: random stall bursts, plus one long hold on request.
  initial begin : result_sink
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        hold          = LONG_HOLD;
        long_hold_req = 1'b0;
        long_holds++;
      end else if (hold == 0 && !quiet && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 7);
      end
      if (hold != 0) begin
        out_tready <= 1'b0;
        hold--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_word(input logic [FUNC_W-1:0] fn, input logic [7:0] data);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= fn;
    do @(posedge clk); while (!in_tready);
    op_count[fn]++;
  endtask

  // Drop valid and wait until every result is back, then let the pipe drain.
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_size(input logic [CFG_W-1:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    size_writes++;
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] value, input int unsigned n,
                           input int unsigned push_pct, input logic with_reset,
                           input logic hold_results);
    int unsigned pick;
    int unsigned rest;
    write_size(value);
    if (hold_results) long_hold_req = 1'b1;
    rest = 100 - push_pct;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < push_pct)
        send_word(FN_PUSH, 8'($urandom_range(0, 255)));
      else if (pick < push_pct + rest * 3 / 4)
        send_word(FN_POP, 8'($urandom_range(0, 255)));
      else if (!with_reset || pick < push_pct + rest * 9 / 10)
        send_word(FN_CLROV, 8'($urandom_range(0, 255)));
      else
        send_word(FN_RESET, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin : stimulus
    for (int i = 0; i < 4; i++) op_count[i] = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset size: pop from empty wraps the read side round to full.
    send_word(FN_POP,   8'h00);
    send_word(FN_RESET, 8'hFF);
    send_word(FN_PUSH,  8'h00);
    send_word(FN_PUSH,  8'hFF);
    send_word(FN_PUSH,  8'h5A);
    send_word(FN_POP,   8'h00);
    send_word(FN_POP,   8'h00);
    send_word(FN_POP,   8'h00);
    send_word(FN_CLROV, 8'h00);

    // Smallest ring: second push meets the read pointer.
    write_size(9'd2);
    send_word(FN_PUSH,  8'hA5);
    send_word(FN_PUSH,  8'h3C);
    send_word(FN_PUSH,  8'h0F);
    send_word(FN_CLROV, 8'h00);
    send_word(FN_POP,   8'h00);

    // Three slots: a wrap that does not overflow, then pop past empty.
    write_size(9'd3);
    send_word(FN_PUSH,  8'h01);
    send_word(FN_PUSH,  8'h02);
    send_word(FN_POP,   8'h00);
    send_word(FN_PUSH,  8'h03);
    send_word(FN_POP,   8'h00);
    send_word(FN_POP,   8'h00);
    send_word(FN_POP,   8'h00);
    send_word(FN_RESET, 8'h00);

    run_phase(9'd2,   20, 50, 1'b1, 1'b0);
    run_phase(9'd3,   20, 50, 1'b1, 1'b0);
    run_phase(9'd7,   20, 55, 1'b1, 1'b0);
    run_phase(9'($urandom_range(2, 256)), 20, 50, 1'b1, 1'b0);
    run_phase(9'd0,   10, 50, 1'b1, 1'b0);
    run_phase(9'd1,   10, 50, 1'b1, 1'b0);
    run_phase(9'd400, 20, 50, 1'b1, 1'b1);
    // full size, push-heavy and no pointer resets so the write side wraps
    run_phase(9'd256, 290, 95, 1'b0, 1'b0);
    run_phase(9'd511, 10, 50, 1'b1, 1'b0);
    quiet = 1'b1;
    run_phase(9'd5,   20, 50, 1'b1, 1'b0);
    settle();

    $display("Sent %0d words: %0d push, %0d pop, %0d pointer reset, %0d overflow clear",
             op_count[FN_PUSH] + op_count[FN_POP] + op_count[FN_RESET] + op_count[FN_CLROV],
             op_count[FN_PUSH], op_count[FN_POP], op_count[FN_RESET], op_count[FN_CLROV]);
    $display("%0d size writes, %0d results checked, %0d wraps, %0d overflows, %0d long stalls",
             size_writes, checked, wrap_count, ovf_count, long_holds);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * 12);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: byte_ring_buffer_with_overflow_flags.f
+incdir+design
design/brb_pkg.sv
design/brb_ctrl.sv
design/brb_dpath.sv
design/byte_ring_buffer_with_overflow_flags.sv
tb/brb_ring_checker.sv
tb/byte_ring_buffer_with_overflow_flags_tb.sv
